### sv/assert_macros.svh
// assertion macros used by the executor top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BMVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BMVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BMVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/bmvm_pkg.sv
`default_nettype none
package bmvm_pkg;

    // store geometry
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int PC_W      = 17;

    // input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    // instruction opcodes
    localparam logic [7:0] OP_STOP  = 8'd0;
    localparam logic [7:0] OP_SET   = 8'd1;
    localparam logic [7:0] OP_MOV   = 8'd2;
    localparam logic [7:0] OP_JMP   = 8'd3;
    localparam logic [7:0] OP_JNT   = 8'd4;
    localparam logic [7:0] OP_ADD   = 8'd5;
    localparam logic [7:0] OP_SUB   = 8'd6;
    localparam logic [7:0] OP_NOT   = 8'd7;
    localparam logic [7:0] OP_AND   = 8'd8;
    localparam logic [7:0] OP_OR    = 8'd9;
    localparam logic [7:0] OP_XOR   = 8'd10;
    localparam logic [7:0] OP_PRINT = 8'd11;
    localparam logic [7:0] OP_SCAN  = 8'd12;
    localparam logic [7:0] OP_JMZ   = 8'd13;
    localparam logic [7:0] OP_JEQ   = 8'd14;
    localparam logic [7:0] OP_JLT   = 8'd15;
    localparam logic [7:0] OP_JGT   = 8'd16;
    localparam logic [7:0] OP_JLE   = 8'd17;
    localparam logic [7:0] OP_JGE   = 8'd18;
    localparam logic [7:0] OP_ADDC  = 8'd19;
    localparam logic [7:0] OP_SUBC  = 8'd20;
    localparam logic [7:0] OP_NOP   = 8'd255;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_STOP   = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_PCEND  = 3'd3;
    localparam logic [2:0] ST_HALTED = 3'd4;
    localparam logic [2:0] ST_UNSUP  = 3'd5;

    typedef struct packed {
        logic        opcode;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] next_pc;
        logic        print_valid;
        logic [7:0]  print_char;
        logic [7:0]  executed_code;
    } t_out;

    // which operand address a data read uses
    typedef enum logic [1:0] {
        ASEL_A = 2'd0,
        ASEL_B = 2'd1,
        ASEL_C = 2'd2
    } t_asel;

    // static decode of one opcode byte
    typedef struct packed {
        logic [2:0] len;
        logic       use_rd1;
        t_asel      rd1_sel;
        logic       use_rd2;
        t_asel      rd2_sel;
    } t_dec;

    // execute result handed from the alu to the sequencer
    typedef struct packed {
        logic [2:0]      status;
        logic            halt;
        logic            we;
        logic [15:0]     waddr;
        logic [7:0]      wdata;
        logic [PC_W-1:0] next_pc;
        logic            print_valid;
        logic [7:0]      print_char;
    } t_exu;

    function automatic t_dec decode_op(input logic [7:0] code);
        t_dec d;
        d = '{len: 3'd1, use_rd1: 1'b0, rd1_sel: ASEL_A, use_rd2: 1'b0, rd2_sel: ASEL_A};
        case (code)
            OP_SET: begin
                d.len = 3'd4;
            end
            OP_MOV, OP_JNT, OP_JMZ: begin
                d.len     = 3'd5;
                d.use_rd2 = 1'b1;
                d.rd2_sel = ASEL_B;
            end
            OP_JMP: begin
                d.len = 3'd3;
            end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                d.len     = 3'd5;
                d.use_rd1 = 1'b1;
                d.rd1_sel = ASEL_A;
                d.use_rd2 = 1'b1;
                d.rd2_sel = ASEL_B;
            end
            OP_NOT, OP_PRINT: begin
                d.len     = 3'd3;
                d.use_rd2 = 1'b1;
                d.rd2_sel = ASEL_A;
            end
            OP_JEQ, OP_JLT, OP_JGT, OP_JLE, OP_JGE: begin
                d.len     = 3'd7;
                d.use_rd1 = 1'b1;
                d.rd1_sel = ASEL_B;
                d.use_rd2 = 1'b1;
                d.rd2_sel = ASEL_C;
            end
            default: begin
                d.len = 3'd1;
            end
        endcase
        return d;
    endfunction

    // assemble a 16-bit operand address from two instruction bytes
    function automatic logic [15:0] opnd_addr(input logic low_first,
                                              input logic [7:0] b0,
                                              input logic [7:0] b1);
        return low_first ? {b1, b0} : {b0, b1};
    endfunction

endpackage
`default_nettype wire

### sv/bmvm_mem.sv
`default_nettype none
module bmvm_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bmvm_pkg::PC_W-1:0] i_addr,
    input  logic [7:0]                i_wdata,
    output logic [7:0]                o_rdata
);
    import bmvm_pkg::*;

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;
    logic       r_ok;
    logic       in_range;

    // addresses past the store are not written and read as zero
    assign in_range = i_addr < PC_W'(MEM_BYTES);

    // single port byte store with a registered read
    always_ff @(posedge i_clk) begin
        if (i_we && in_range) begin
            r_mem[i_addr[MEM_AW-1:0]] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr[MEM_AW-1:0]];
        r_ok    <= in_range;
    end

    assign o_rdata = r_ok ? r_rdata : 8'd0;

endmodule
`default_nettype wire

### sv/bmvm_alu.sv
`default_nettype none
module bmvm_alu (
    input  logic [7:0]                i_code,
    input  logic [bmvm_pkg::PC_W-1:0] i_pc,
    input  logic [15:0]               i_a,
    input  logic [7:0]                i_set_byte,
    input  logic [7:0]                i_v1,
    input  logic [7:0]                i_v2,
    output bmvm_pkg::t_exu            o_exu
);
    import bmvm_pkg::*;

    t_dec            dec;
    logic [PC_W-1:0] fall_pc;
    logic            is_jcc;
    logic            cond;

    assign dec     = decode_op(i_code);
    assign fall_pc = i_pc + PC_W'(dec.len);

    // instruction execute: data path, write-back and next pc
    always_comb begin
        o_exu = '{status: ST_OK, halt: 1'b0, we: 1'b0, waddr: i_a, wdata: 8'd0,
                  next_pc: fall_pc, print_valid: 1'b0, print_char: 8'd0};
        is_jcc = 1'b0;
        cond   = 1'b0;
        case (i_code)
            OP_NOP: begin
                o_exu.next_pc = fall_pc;
            end
            OP_STOP: begin
                o_exu.status  = ST_STOP;
                o_exu.halt    = 1'b1;
                o_exu.next_pc = i_pc;
            end
            OP_SET: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_set_byte;
            end
            OP_MOV: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v2;
            end
            OP_JMP: begin
                o_exu.next_pc = {1'b0, i_a};
            end
            OP_JNT: begin
                is_jcc = 1'b1;
                cond   = i_v2 != 8'd0;
            end
            OP_JMZ: begin
                is_jcc = 1'b1;
                cond   = i_v2 == 8'd0;
            end
            OP_ADD: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v1 + i_v2;
            end
            OP_SUB: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v1 - i_v2;
            end
            OP_NOT: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = ~i_v2;
            end
            OP_AND: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v1 & i_v2;
            end
            OP_OR: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v1 | i_v2;
            end
            OP_XOR: begin
                o_exu.we    = 1'b1;
                o_exu.wdata = i_v1 ^ i_v2;
            end
            OP_PRINT: begin
                o_exu.print_valid = 1'b1;
                o_exu.print_char  = i_v2;
            end
            OP_JEQ: begin
                is_jcc = 1'b1;
                cond   = i_v1 == i_v2;
            end
            OP_JLT: begin
                is_jcc = 1'b1;
                cond   = i_v1 < i_v2;
            end
            OP_JGT: begin
                is_jcc = 1'b1;
                cond   = i_v1 > i_v2;
            end
            OP_JLE: begin
                is_jcc = 1'b1;
                cond   = i_v1 <= i_v2;
            end
            OP_JGE: begin
                is_jcc = 1'b1;
                cond   = i_v1 >= i_v2;
            end
            OP_SCAN, OP_ADDC, OP_SUBC: begin
                o_exu.status  = ST_UNSUP;
                o_exu.halt    = 1'b1;
                o_exu.next_pc = i_pc;
            end
            default: begin
                o_exu.status  = ST_BADOP;
                o_exu.halt    = 1'b1;
                o_exu.next_pc = i_pc;
            end
        endcase
        // taken branch loads the target, else falls through
        if (is_jcc && cond) begin
            o_exu.next_pc = {1'b0, i_a};
        end
    end

endmodule
`default_nettype wire

### sv/byte_memory_vm_executor_top.sv
// byte machine executor: a 64 KiB byte store plus a program counter.
// command channel: an item is taken when start is high and busy is low.
// a load item writes one byte; an execute item runs one instruction at pc.
// each item gives one result on o_result, marked by o_valid for one cycle;
// the receiver cannot stall, so results are never held.
// configuration: i_cfg_we writes the operand address byte order (i_cfg_wdata)
// in any cycle; it is meant to change only while the block is idle.
// load, execute while halted, pc past the store: busy stays low.
// execute: busy stays high while the instruction (1 to 7 bytes, len) is
// fetched, then for 0 to 2 data reads, then for the write-back.
// the single port byte store sets this: one byte per cycle for the opcode
// and operands, then the data reads, then the write-back.
// the result strobe comes in the cycle after the last busy cycle.
// after reset a clearing pass zeroes the store, one byte per cycle, for
// all MEM_BYTES (65536) bytes with busy high; config writes still land.
`default_nettype none
`include "assert_macros.svh"
module byte_memory_vm_executor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bmvm_pkg::t_in  i_item,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    output logic           o_valid,
    output bmvm_pkg::t_out o_result
);
    import bmvm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_RD1   = 6'b001000,
        S_RD2   = 6'b010000,
        S_EXEC  = 6'b100000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [MEM_AW-1:0] r_clr;
    logic [PC_W-1:0] r_pc;
    logic            r_halted;
    logic            r_order;
    logic [2:0]      r_k;
    logic [7:0]      r_ibuf [7];
    logic [7:0]      r_v1;
    logic            r_valid;
    t_out            r_res;

    logic            mem_we;
    logic [PC_W-1:0] mem_addr;
    logic [7:0]      mem_wdata;
    logic [7:0]      mem_rdata;

    logic            acc;
    logic            acc_load;
    logic            acc_exec;
    logic            acc_run;
    logic            pc_ok;
    logic [7:0]      code_now;
    t_dec            dec_now;
    t_dec            dec;
    logic [15:0]     op_a;
    logic [15:0]     op_b;
    logic [15:0]     op_c;
    logic [15:0]     rd1_addr;
    logic [15:0]     rd2_addr;
    t_exu            exu;

    // command transaction
    assign busy     = r_state != S_IDLE;
    assign acc      = start && !busy;
    assign acc_load = acc && (i_item.opcode == CMD_LOAD);
    assign acc_exec = acc && (i_item.opcode == CMD_EXEC);
    assign pc_ok    = r_pc < PC_W'(MEM_BYTES);
    // execute transaction that actually runs an instruction
    assign acc_run  = acc_exec && !r_halted && pc_ok;

    // opcode byte arrives from the store while r_k is 1
    assign code_now = (r_k == 3'd1) ? mem_rdata : r_ibuf[0];
    assign dec_now  = decode_op(code_now);
    assign dec      = decode_op(r_ibuf[0]);

    // operand addresses from the buffered instruction bytes
    assign op_a = opnd_addr(r_order, r_ibuf[1], r_ibuf[2]);
    assign op_b = opnd_addr(r_order, r_ibuf[3], r_ibuf[4]);
    assign op_c = opnd_addr(r_order, r_ibuf[5], r_ibuf[6]);

    always_comb begin
        case (dec.rd1_sel)
            ASEL_A:  rd1_addr = op_a;
            ASEL_B:  rd1_addr = op_b;
            ASEL_C:  rd1_addr = op_c;
            default: rd1_addr = op_a;
        endcase
        case (dec.rd2_sel)
            ASEL_A:  rd2_addr = op_a;
            ASEL_B:  rd2_addr = op_b;
            ASEL_C:  rd2_addr = op_c;
            default: rd2_addr = op_a;
        endcase
    end

    bmvm_alu u_alu (
        .i_code     (r_ibuf[0]),
        .i_pc       (r_pc),
        .i_a        (op_a),
        .i_set_byte (r_ibuf[3]),
        .i_v1       (r_v1),
        .i_v2       (mem_rdata),
        .o_exu      (exu)
    );

    bmvm_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // store port: one access per cycle, the sequencer never overlaps
    // a write with a read of the same byte, so no forwarding is needed
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc + PC_W'(r_k);
        mem_wdata = 8'd0;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = PC_W'(r_clr);
            end
            S_IDLE: begin
                mem_we    = acc_load;
                mem_addr  = {1'b0, i_item.load_address};
                mem_wdata = i_item.load_data;
            end
            S_FETCH: begin
                mem_addr = r_pc + PC_W'(r_k);
            end
            S_RD1: begin
                mem_addr = {1'b0, rd1_addr};
            end
            S_RD2: begin
                mem_addr = {1'b0, rd2_addr};
            end
            S_EXEC: begin
                mem_we    = exu.we;
                mem_addr  = {1'b0, exu.waddr};
                mem_wdata = exu.wdata;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == MEM_AW'(MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc_run) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_k != 3'd0 && r_k == dec_now.len) begin
                    if (dec_now.use_rd1) begin
                        n_state = S_RD1;
                    end else if (dec_now.use_rd2) begin
                        n_state = S_RD2;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_order  <= 1'b0;
            r_k      <= 3'd0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (acc && !acc_run) || (r_state == S_EXEC);
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + MEM_AW'(1);
            end
            if (r_state == S_FETCH) begin
                r_k <= r_k + 3'd1;
            end else begin
                r_k <= 3'd0;
            end
            if (acc_exec && !r_halted && !pc_ok) begin
                r_halted <= 1'b1;
            end
            if (r_state == S_EXEC) begin
                r_pc <= exu.next_pc;
                if (exu.halt) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

    // instruction bytes, first operand value and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH && r_k != 3'd0) begin
            r_ibuf[3'(r_k - 3'd1)] <= mem_rdata;
        end
        if (r_state == S_RD2) begin
            r_v1 <= mem_rdata;
        end
        if (acc) begin
            r_res <= '{status: acc_exec ? (r_halted ? ST_HALTED : ST_PCEND) : ST_OK,
                       next_pc: r_pc[15:0], print_valid: 1'b0,
                       print_char: 8'd0, executed_code: 8'd0};
        end else if (r_state == S_EXEC) begin
            r_res <= '{status: exu.status, next_pc: exu.next_pc[15:0],
                       print_valid: exu.print_valid, print_char: exu.print_char,
                       executed_code: r_ibuf[0]};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    // checks
    `BMVM_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, acc_load, o_valid && o_result.status == ST_OK, "load transaction gave no ok result")
    `BMVM_ASSERT_NXT(a_halted_exec, i_clk, i_rst_n, acc_exec && r_halted, o_valid && o_result.status == ST_HALTED, "execute while halted not reported")
    `BMVM_ASSERT_IMP(a_halt_reported, i_clk, i_rst_n, $rose(r_halted), o_valid && (o_result.status == ST_STOP || o_result.status == ST_BADOP || o_result.status == ST_PCEND || o_result.status == ST_UNSUP), "halt without halting status")
    `BMVM_ASSERT_NXT(a_exec_result, i_clk, i_rst_n, r_state == S_EXEC, o_valid && !busy, "execute cycle gave no result")

endmodule
`default_nettype wire

### bench/byte_machine_checker.sv
module byte_machine_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  bmvm_pkg::t_in    i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    input  bmvm_pkg::t_out   i_result,
    output int               o_fail_count,
    output int               o_outstanding
);
    import bmvm_pkg::*;

    // shadow copy of the machine state
    logic [7:0]  shadow_mem [MEM_BYTES];
    logic [16:0] shadow_pc;
    logic        shadow_halted;
    logic        low_first;
    t_out        expected_q [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what);
        $display("%0t: checker: %s", $time, what);
        o_fail_count++;
    endtask

    // store reads and writes, zero and ignored past the end
    function automatic logic [7:0] peek(input logic [16:0] addr);
        return (addr < MEM_BYTES) ? shadow_mem[addr] : 8'h00;
    endfunction

    function automatic void poke(input logic [16:0] addr, input logic [7:0] data);
        if (addr < MEM_BYTES) begin
            shadow_mem[addr] = data;
        end
    endfunction

    // 16-bit operand address from two instruction bytes
    function automatic logic [15:0] operand_at(input logic [16:0] p);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = peek(p);
        b1 = peek(p + 17'd1);
        return low_first ? {b1, b0} : {b0, b1};
    endfunction

    // apply one transaction to the shadow state and build its result
    function automatic t_out execute_item(input t_in it);
        t_out        r;
        logic [16:0] pc;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [7:0]  va;
        logic [7:0]  vb;
        logic [7:0]  vc;
        logic [7:0]  code;
        int          taken;
        r  = '0;
        pc = shadow_pc;
        if (it.opcode == CMD_LOAD) begin
            poke({1'b0, it.load_address}, it.load_data);
        end else if (shadow_halted) begin
            r.status = ST_HALTED;
        end else if (pc >= MEM_BYTES) begin
            r.status      = ST_PCEND;
            shadow_halted = 1'b1;
        end else begin
            a     = operand_at(pc + 17'd1);
            b     = operand_at(pc + 17'd3);
            c     = operand_at(pc + 17'd5);
            va    = peek({1'b0, a});
            vb    = peek({1'b0, b});
            vc    = peek({1'b0, c});
            code  = peek(pc);
            taken = -1;
            case (code)
                OP_NOP:   pc = pc + 17'd1;
                OP_STOP: begin
                    r.status      = ST_STOP;
                    shadow_halted = 1'b1;
                end
                OP_SET: begin
                    poke({1'b0, a}, peek(pc + 17'd3));
                    pc = pc + 17'd4;
                end
                OP_MOV: begin
                    poke({1'b0, a}, vb);
                    pc = pc + 17'd5;
                end
                OP_JMP:   pc = {1'b0, a};
                OP_JNT:   taken = int'(vb != 8'h00);
                OP_ADD: begin
                    poke({1'b0, a}, va + vb);
                    pc = pc + 17'd5;
                end
                OP_SUB: begin
                    poke({1'b0, a}, va - vb);
                    pc = pc + 17'd5;
                end
                OP_NOT: begin
                    poke({1'b0, a}, ~va);
                    pc = pc + 17'd3;
                end
                OP_AND: begin
                    poke({1'b0, a}, va & vb);
                    pc = pc + 17'd5;
                end
                OP_OR: begin
                    poke({1'b0, a}, va | vb);
                    pc = pc + 17'd5;
                end
                OP_XOR: begin
                    poke({1'b0, a}, va ^ vb);
                    pc = pc + 17'd5;
                end
                OP_PRINT: begin
                    r.print_valid = 1'b1;
                    r.print_char  = va;
                    pc = pc + 17'd3;
                end
                OP_JMZ:   taken = int'(vb == 8'h00);
                OP_JEQ:   taken = int'(vb == vc);
                OP_JLT:   taken = int'(vb < vc);
                OP_JGT:   taken = int'(vb > vc);
                OP_JLE:   taken = int'(vb <= vc);
                OP_JGE:   taken = int'(vb >= vc);
                OP_SCAN, OP_ADDC, OP_SUBC: begin
                    r.status      = ST_UNSUP;
                    shadow_halted = 1'b1;
                end
                default: begin
                    r.status      = ST_BADOP;
                    shadow_halted = 1'b1;
                end
            endcase
            // conditional jumps: taken loads the target, else skip the instruction
            if (taken > 0) begin
                pc = {1'b0, a};
            end else if (taken == 0) begin
                pc = pc + ((code == OP_JNT || code == OP_JMZ) ? 17'd5 : 17'd7);
            end
            shadow_pc       = pc;
            r.executed_code = code;
        end
        r.next_pc = shadow_pc[15:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // compare on the result strobe, then take in a new transaction
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
            shadow_pc     = '0;
            shadow_halted = 1'b0;
            low_first     = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                low_first = i_cfg_wdata;
            end
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 16'(i_result.status), 16'(want.status));
                    check_field("next_pc", i_result.next_pc, want.next_pc);
                    check_field("print_valid", 16'(i_result.print_valid),
                                16'(want.print_valid));
                    check_field("print_char", 16'(i_result.print_char),
                                16'(want.print_char));
                    check_field("executed_code", 16'(i_result.executed_code),
                                16'(want.executed_code));
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(execute_item(i_item));
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

### bench/tb_byte_memory_vm_executor_top.sv
module tb_byte_memory_vm_executor_top;
    import bmvm_pkg::*;

    localparam int RUN_LIMIT   = 5_000_000;
    localparam int ITEM_TARGET = 1100;
    localparam int NUM_PHASES  = 4;
    // highest jump target used while running, keeps pc clear of the store end
    localparam int LAST_TARGET = 16'hFFF0;
    localparam int NUM_OPS     = 18;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    t_in            i_item;
    logic           i_cfg_we;
    logic           i_cfg_wdata;
    logic           o_valid;
    t_out           o_result;

    int             fail_count;
    int             outstanding;
    logic [15:0]    seen_pc;
    logic           byte_order;
    int             items_sent;
    int             idle_max;

    always #5 i_clk = ~i_clk;

    byte_memory_vm_executor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    byte_machine_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // track where the machine stands so the next instruction lands at pc
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seen_pc <= '0;
        end else if (o_valid) begin
            seen_pc <= o_result.next_pc;
        end
    end

    // one transaction: random gap, then hold start until busy is low
    task automatic send_item(input t_in item);
        int gap;
        gap = $urandom_range(0, idle_max);
        repeat (gap) @(negedge i_clk);
        start  = 1'b1;
        i_item = item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start = 1'b0;
        items_sent++;
    endtask

    task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
        t_in it;
        it.opcode       = CMD_LOAD;
        it.load_address = addr;
        it.load_data    = data;
        send_item(it);
    endtask

    // execute one instruction; the load fields carry junk
    task automatic step_once();
        t_in it;
        it.opcode       = CMD_EXEC;
        it.load_address = 16'($urandom);
        it.load_data    = 8'($urandom);
        send_item(it);
    endtask

    task automatic put_addr(input logic [15:0] at, input logic [15:0] value);
        load_byte(at, byte_order ? value[7:0] : value[15:8]);
        load_byte(at + 16'd1, byte_order ? value[15:8] : value[7:0]);
    endtask

    task automatic drain();
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_order(input logic value);
        drain();
        repeat (16) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        byte_order  = value;
    endtask

    function automatic int instr_len(input logic [7:0] code);
        case (code)
            OP_NOP:                          return 1;
            OP_JMP, OP_NOT, OP_PRINT:        return 3;
            OP_SET:                          return 4;
            OP_JEQ, OP_JLT, OP_JGT, OP_JLE,
            OP_JGE:                          return 7;
            default:                         return 5;
        endcase
    endfunction

    function automatic logic is_branch(input logic [7:0] code);
        case (code)
            OP_JMP, OP_JNT, OP_JMZ, OP_JEQ, OP_JLT, OP_JGT, OP_JLE,
            OP_JGE:  return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] op_by_index(input int k);
        case (k)
            0:       return OP_NOP;
            1:       return OP_SET;
            2:       return OP_MOV;
            3:       return OP_JMP;
            4:       return OP_JNT;
            5:       return OP_ADD;
            6:       return OP_SUB;
            7:       return OP_NOT;
            8:       return OP_AND;
            9:       return OP_OR;
            10:      return OP_XOR;
            11:      return OP_PRINT;
            12:      return OP_JMZ;
            13:      return OP_JEQ;
            14:      return OP_JLT;
            15:      return OP_JGT;
            16:      return OP_JLE;
            default: return OP_JGE;
        endcase
    endfunction

    // data byte biased toward zero and all ones
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll < 2) return 8'h00;
        if (roll == 2) return 8'hFF;
        return 8'($urandom);
    endfunction

    // write data operands, then the instruction at pc with its opcode last, then run it
    task automatic run_instr(input logic [7:0] code, input logic [15:0] a,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [7:0] va, input logic [7:0] vb,
                             input logic [7:0] vc);
        logic [15:0] pc;
        int          n;
        drain();
        pc = seen_pc;
        n  = instr_len(code);
        if (n >= 3 && !is_branch(code)) load_byte(a, va);
        if (n >= 5) load_byte(b, vb);
        if (n == 7) load_byte(c, vc);
        if (n >= 3) put_addr(pc + 16'd1, a);
        if (n == 4) load_byte(pc + 16'd3, vb);
        if (n >= 5) put_addr(pc + 16'd3, b);
        if (n == 7) put_addr(pc + 16'd5, c);
        load_byte(pc, code);
        step_once();
    endtask

    // jump at the top of the store: its second address byte reads as zero
    task automatic jump_from_top();
        run_instr(OP_JMP, 16'hFFFE, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        load_byte(16'hFFFE, OP_JMP);
        load_byte(16'hFFFF, 8'($urandom));
        step_once();
    endtask

    // one well-formed instruction with random operands, sometimes followed by stray loads
    task automatic random_instr();
        logic [7:0]  code;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [7:0]  vb;
        logic [7:0]  vc;
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        drain();
        code = op_by_index($urandom_range(0, NUM_OPS - 1));
        if (seen_pc > LAST_TARGET) code = OP_JMP;
        b  = 16'($urandom);
        c  = ($urandom_range(0, 7) == 0) ? b : 16'($urandom);
        vb = pick_byte();
        vc = ($urandom_range(0, 2) == 0) ? vb : pick_byte();
        a  = is_branch(code) ? 16'($urandom_range(0, LAST_TARGET)) : 16'($urandom);
        run_instr(code, a, b, c, pick_byte(), vb, vc);
        while ($urandom_range(0, 5) == 0) load_byte(16'($urandom), 8'($urandom));
    endtask

    // end the program with one of the halting cases, then poke the halted machine
    task automatic halt_machine();
        int why;
        drain();
        why = $urandom_range(0, 3);
        case (why)
            0: load_byte(seen_pc, OP_STOP);
            1: load_byte(seen_pc, 8'($urandom_range(OP_SUBC + 1, OP_NOP - 1)));
            2: begin
                case ($urandom_range(0, 2))
                    0:       load_byte(seen_pc, OP_SCAN);
                    1:       load_byte(seen_pc, OP_ADDC);
                    default: load_byte(seen_pc, OP_SUBC);
                endcase
            end
            default: begin
                // nop in the last byte walks pc off the end of the store
                run_instr(OP_JMP, 16'hFFFF, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
                load_byte(16'hFFFF, OP_NOP);
                step_once();
            end
        endcase
        step_once();
        step_once();
        load_byte(16'($urandom), 8'($urandom));
        step_once();
    endtask

    initial begin
        int phase;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_rst_n     = 1'b0;
        byte_order  = 1'b0;
        items_sent  = 0;
        idle_max    = 3;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_order(1'b0);

        // directed: extreme loads, wrapping add and subtract, jump off the top
        load_byte(16'hFFFF, 8'hFF);
        load_byte(16'h0000, 8'h00);
        run_instr(OP_ADD, 16'h8000, 16'h7FFF, 16'h0000, 8'hFF, 8'h01, 8'h00);
        run_instr(OP_SUB, 16'h8000, 16'h7FFF, 16'h0000, 8'h00, 8'h01, 8'h00);
        run_instr(OP_JMP, 16'hFFFE, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        load_byte(16'hFFFE, OP_JMP);
        load_byte(16'hFFFF, 8'h12);
        step_once();

        // random programs, alternating the operand byte order per phase
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_order(~phase[0]);
            jump_from_top();
            while (items_sent < (phase + 1) * ITEM_TARGET / NUM_PHASES) random_instr();
        end
        halt_machine();

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_byte_memory_vm_executor_top OK");
        end else begin
            $display("tb_byte_memory_vm_executor_top NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("tb_byte_memory_vm_executor_top NOT OK");
        $finish;
    end

endmodule
